FILE: rtl/core/bse_pkg.sv
// Package for the binary search engine: widths, codes and sequencer states.
package bse_pkg;

   // Default table depth
   localparam int TABLE_DEPTH_DEF = 8192;

   // Field widths
   localparam int FUNC_W        = 1;
   localparam int ENTRY_INDEX_W = 13;
   localparam int VALUE_W       = 32;
   localparam int PROBE_W       = 4;
   localparam int COUNT_W       = 14;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ENTRY_COUNT = 1'b0;

   // Item function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

   // Probe counter ceiling
   localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

   // Search sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP
   } state_type;

endpackage

FILE: rtl/core/bse_req_if.sv
// Request channel interface: load and search items.
interface bse_req_if;
   logic                                valid;
   logic                                ready;
   logic [bse_pkg::FUNC_W-1:0]          func;
   logic [bse_pkg::ENTRY_INDEX_W-1:0]   entry_index;
   logic signed [bse_pkg::VALUE_W-1:0]  entry_value;
   logic signed [bse_pkg::VALUE_W-1:0]  search_key;

   modport source (output valid, func, entry_index, entry_value, search_key, input ready);
   modport sink   (input valid, func, entry_index, entry_value, search_key, output ready);
endinterface

FILE: rtl/core/bse_rsp_if.sv
// Response channel interface: search results.
interface bse_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic [bse_pkg::ENTRY_INDEX_W-1:0]   match_index;
   logic [bse_pkg::PROBE_W-1:0]         probe_count;

   modport source (output valid, found, match_index, probe_count, input ready);
   modport sink   (input valid, found, match_index, probe_count, output ready);
endinterface

FILE: rtl/core/bse_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/binary_search_engine_top.sv
// Binary search engine top level: table RAM, halving sequencer and CSR port.
//
//  channel   direction  handshake          payload
//  req_chan  in         valid/ready        func, entry_index, entry_value, search_key
//  rsp_chan  out        valid/ready        found, match_index, probe_count
//  csr_*     in         APB psel/penable   entry_count at byte address 0
//
// A load item is written to the table when it is accepted. A search is accepted in the idle
// state; each probe is a RAM read step, then a compare step, until a match or an empty range.
// The single RAM read port paces the probes. The table has no reset and no clearing pass.
// A finished result sits in the output register; loads are taken while it waits, and a
// search that ends while the previous result is still pending holds in the compare step.
module binary_search_engine_top #(
   parameter int TABLE_DEPTH = bse_pkg::TABLE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   bse_req_if.sink                          req_chan,
   bse_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bse_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bse_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bse_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int AW = $clog2(TABLE_DEPTH);   // table address
   localparam int NW = AW + 1;                // holds the depth itself
   localparam int PW = AW + 2;                // signed range bounds

   // Configuration register
   logic [bse_pkg::COUNT_W-1:0] count_ff;
   logic                        count_dflt_ff;
   logic                        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == bse_pkg::REG_ENTRY_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= bse_pkg::COUNT_W'(TABLE_DEPTH);
         count_dflt_ff <= 1'b1;
      end else if (csr_wr) begin
         count_ff      <= csr_pwdata[bse_pkg::COUNT_W-1:0];
         count_dflt_ff <= 1'b0;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == bse_pkg::REG_ENTRY_COUNT) begin
         if (count_dflt_ff && (count_ff == '0)) begin
            csr_prdata = bse_pkg::CSR_DATA_W'(TABLE_DEPTH);
         end else begin
            csr_prdata = bse_pkg::CSR_DATA_W'(count_ff);
         end
      end
   end

   // Effective search length, clamped to 1..depth
   logic [NW-1:0] n_eff;

   always_comb begin
      if (count_dflt_ff) begin
         n_eff = NW'(TABLE_DEPTH);
      end else if (count_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         n_eff = NW'(TABLE_DEPTH);
      end else begin
         n_eff = NW'(count_ff);
      end
   end

   // Sequencer registers
   bse_pkg::state_type                    state_ff, state_in;
   logic signed [PW-1:0]                  low_ff, low_in;
   logic signed [PW-1:0]                  high_ff, high_in;
   logic [AW-1:0]                         mid_ff, mid_in;
   logic signed [bse_pkg::VALUE_W-1:0]    key_ff, key_in;
   logic [bse_pkg::PROBE_W-1:0]           probe_ff, probe_in;

   // Result register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  found_ff, found_in;
   logic [bse_pkg::ENTRY_INDEX_W-1:0]     match_ff, match_in;
   logic [bse_pkg::PROBE_W-1:0]           rsp_probe_ff, rsp_probe_in;

   // RAM ports
   logic                                  ram_wr_en;
   logic [AW-1:0]                         ram_wr_addr;
   logic                                  ram_rd_en;
   logic [bse_pkg::VALUE_W-1:0]           ram_rd_data;

   logic                                  req_fire;
   logic [PW-1:0]                         sum_w;
   logic signed [PW-1:0]                  mid_ext;
   logic signed [PW-1:0]                  next_low;
   logic signed [PW-1:0]                  next_high;
   logic                                  key_eq;
   logic                                  key_gt;
   logic                                  slot_free;

   assign req_chan.ready = (state_ff == bse_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // Midpoint of the live range (bounds are nonnegative while probing)
   assign sum_w   = low_ff + high_ff;
   assign mid_ext = $signed(PW'(mid_ff));
   assign key_eq  = (key_ff == $signed(ram_rd_data));
   assign key_gt  = (key_ff > $signed(ram_rd_data));
   assign next_low  = key_gt ? (mid_ext + PW'(1)) : low_ff;
   assign next_high = key_gt ? high_ff : (mid_ext - PW'(1));

   // Load write port
   assign ram_wr_en   = req_fire && (req_chan.func == bse_pkg::FUNC_LOAD)
                        && (32'(req_chan.entry_index) < 32'(TABLE_DEPTH));
   assign ram_wr_addr = AW'(req_chan.entry_index);
   assign ram_rd_en   = (state_ff == bse_pkg::ST_READ);

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      found_in     = found_ff;
      match_in     = match_ff;
      rsp_probe_in = rsp_probe_ff;

      unique case (state_ff)
         bse_pkg::ST_IDLE: begin
            if (req_fire && (req_chan.func == bse_pkg::FUNC_SEARCH)) begin
               key_in   = req_chan.search_key;
               low_in   = '0;
               high_in  = $signed(PW'(n_eff)) - PW'(1);
               probe_in = '0;
               state_in = bse_pkg::ST_READ;
            end
         end
         bse_pkg::ST_READ: begin
            mid_in   = sum_w[AW:1];
            state_in = bse_pkg::ST_CMP;
         end
         bse_pkg::ST_CMP: begin
            if (key_eq || (next_low > next_high)) begin
               // search ends: post the result once the output slot is free
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  found_in     = key_eq;
                  match_in     = key_eq ? bse_pkg::ENTRY_INDEX_W'(mid_ff) : '0;
                  rsp_probe_in = (probe_ff == bse_pkg::PROBE_MAX) ? probe_ff
                                                                   : probe_ff + 1'b1;
                  state_in     = bse_pkg::ST_IDLE;
               end
            end else begin
               low_in   = next_low;
               high_in  = next_high;
               probe_in = (probe_ff == bse_pkg::PROBE_MAX) ? probe_ff : probe_ff + 1'b1;
               state_in = bse_pkg::ST_READ;
            end
         end
         default: begin
            state_in = bse_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bse_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      probe_ff     <= probe_in;
      found_ff     <= found_in;
      match_ff     <= match_in;
      rsp_probe_ff <= rsp_probe_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = found_ff;
   assign rsp_chan.match_index = match_ff;
   assign rsp_chan.probe_count = rsp_probe_ff;

   // Sorted table storage
   bse_ram #(
      .WIDTH (bse_pkg::VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_chan.entry_value),
      .rd_en   (ram_rd_en),
      .rd_addr (sum_w[AW:1]),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTH
   // A posted result always counts at least one probe
   a_probe_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.probe_count != '0))
      else $error("result with zero probes");

   // A miss reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |-> (rsp_chan.match_index == '0))
      else $error("miss with nonzero index");

   // The range is never empty while a probe is in flight
   a_range_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bse_pkg::ST_READ) |-> ((low_ff <= high_ff) && (low_ff >= 0)))
      else $error("probe issued on an empty range");

   // An accepted search starts probing in the next cycle
   a_search_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.func == bse_pkg::FUNC_SEARCH)) |=>
      (state_ff == bse_pkg::ST_READ))
      else $error("search did not start");

   // A pending result is not overwritten by a finishing search
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff)
      else $error("pending result dropped");
`endif

endmodule
